@@ design/bls_pkg.sv @@
// ---------------------------------------------------------------------------
// bls_pkg: shared types and constants for the line stepper
// Transaction payloads, the command word passed from front to back, and
// request codes.
// ---------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

   localparam int COORD_W = 10;
   localparam int SPAN2_W = 11;
   localparam int ERR_W   = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // request codes carried in req_type
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [SPAN2_W-1:0] span2_type;
   typedef logic [ERR_W-1:0]   err_type;

   typedef struct packed {
      logic      req_type;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
   } req_item_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
   } rsp_item_type;

   // classified command: a step, or a fully set-up line
   typedef struct packed {
      logic      kind;
      logic      active;
      logic      is_steep;
      logic      minor_dir_down;
      coord_type major_pos;
      coord_type major_stop;
      coord_type minor_pos;
      err_type   doubled_error;
      span2_type twice_major_span;
      span2_type twice_minor_span;
   } cmd_type;

   // handshake between queue and back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

`default_nettype wire

@@ design/bresenham_line_stepper_unit.sv @@
// Path: a step transaction's pixel passes through the command queue; the
//   stepper then loads it into the output register that drives rsp_valid.
// Throughput: one transaction per clock while rsp_ready does not hold the
//   output; the two-entry queue and the output register let a new request
//   enter while a pixel waits on rsp_ready, until the queue is full.
// Reset: clears the queue, the active-line flag and the pending pixel.
// ---------------------------------------------------------------------------
// bresenham_line_stepper_unit: line pixel generator
// Front end sets up each line, a queue decouples it from the stepper that
// emits one pixel per step transaction while a line is active.
// ---------------------------------------------------------------------------
`default_nettype none

module bresenham_line_stepper_unit #(
   parameter int MAX_COORD = 512
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire bls_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output bls_pkg::rsp_item_type      rsp_data
);

   bls_pkg::cmd_type      front_cmd;
   bls_pkg::cmd_chan_type queue_chan;
   logic                  back_ready;

   bls_front #(
      .MAX_COORD(MAX_COORD)
   ) u_front (
      .req_item (req_data),
      .cmd      (front_cmd)
   );

   bls_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_cmd   (front_cmd),
      .pop_chan   (queue_chan),
      .pop_ready  (back_ready)
   );

   bls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_chan  (queue_chan),
      .cmd_ready (back_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ design/bls_front.sv @@
// ---------------------------------------------------------------------------
// bls_front: line setup
// Clamps the endpoints, picks the major axis, orders the endpoints along it
// and derives the spans and the initial error term for a start transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module bls_front #(
   parameter int MAX_COORD = 512
) (
   input  wire bls_pkg::req_item_type req_item,
   output bls_pkg::cmd_type           cmd
);

   localparam bls_pkg::coord_type CLAMP_VAL = bls_pkg::coord_type'(MAX_COORD);

   function automatic bls_pkg::coord_type clamp(input bls_pkg::coord_type v);
      bls_pkg::coord_type c;
      c = v;
      if (int'(v) > MAX_COORD) begin
         c = CLAMP_VAL;
      end
      return c;
   endfunction

   function automatic bls_pkg::coord_type span(input bls_pkg::coord_type a,
                                                input bls_pkg::coord_type b);
      return (a > b) ? a - b : b - a;
   endfunction

   bls_pkg::coord_type xa, ya, xb, yb;
   bls_pkg::coord_type ma0, na0, mb0, nb0;
   bls_pkg::coord_type ma, na, mb, nb;
   bls_pkg::coord_type dmaj, dmin;
   logic               steep;

   always_comb begin
      // saturate inputs
      xa = clamp(req_item.x_start);
      ya = clamp(req_item.y_start);
      xb = clamp(req_item.x_end);
      yb = clamp(req_item.y_end);

      // choose major axis
      steep = span(ya, yb) > span(xa, xb);
      ma0 = steep ? ya : xa;
      na0 = steep ? xa : ya;
      mb0 = steep ? yb : xb;
      nb0 = steep ? xb : yb;

      // order along major axis
      if (ma0 > mb0) begin
         ma = mb0; na = nb0; mb = ma0; nb = na0;
      end else begin
         ma = ma0; na = na0; mb = mb0; nb = nb0;
      end

      dmaj = mb - ma;
      dmin = span(na, nb);

      cmd.kind             = req_item.req_type;
      cmd.active           = (dmaj != '0);
      cmd.is_steep         = steep;
      cmd.minor_dir_down   = !(na < nb);
      cmd.major_pos        = ma;
      cmd.major_stop       = mb;
      cmd.minor_pos        = na;
      cmd.doubled_error    = bls_pkg::err_type'(dmaj);
      cmd.twice_major_span = {dmaj, 1'b0};
      cmd.twice_minor_span = {dmin, 1'b0};
   end

endmodule

`default_nettype wire

@@ design/bls_queue.sv @@
// ---------------------------------------------------------------------------
// bls_queue: command queue
// Short FIFO between setup and stepping so that each side stalls on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module bls_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push_valid,
   output logic                      push_ready,
   input  wire bls_pkg::cmd_type     push_cmd,
   output bls_pkg::cmd_chan_type     pop_chan,
   input  wire                       pop_ready
);

   localparam logic [bls_pkg::QPTR_W:0] FULL_CNT = (bls_pkg::QPTR_W + 1)'(bls_pkg::QUEUE_DEPTH);

   bls_pkg::cmd_type            mem_ff [bls_pkg::QUEUE_DEPTH];
   logic [bls_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [bls_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [bls_pkg::QPTR_W:0]    count_ff, count_in;
   logic                        do_push, do_pop;

   assign push_ready     = (count_ff != FULL_CNT);
   assign pop_chan.valid = (count_ff != '0);
   assign pop_chan.cmd   = mem_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_chan.valid && pop_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == bls_pkg::QPTR_W'(bls_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == bls_pkg::QPTR_W'(bls_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ design/bls_back.sv @@
// ---------------------------------------------------------------------------
// bls_back: pixel stepper
// Holds the active line, emits one pixel per step command while a line is
// active into an output register and updates the doubled error term.
// ---------------------------------------------------------------------------
`default_nettype none

module bls_back (
   input  wire                        clock,
   input  wire                        reset,
   input  wire bls_pkg::cmd_chan_type cmd_chan,
   output logic                       cmd_ready,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output bls_pkg::rsp_item_type      rsp_data
);

   logic                  line_active_ff, line_active_in;
   logic                  is_steep_ff, is_steep_in;
   logic                  minor_dir_down_ff, minor_dir_down_in;
   bls_pkg::coord_type    major_pos_ff, major_pos_in;
   bls_pkg::coord_type    major_stop_ff, major_stop_in;
   bls_pkg::coord_type    minor_pos_ff, minor_pos_in;
   bls_pkg::err_type      err_ff, err_in;
   bls_pkg::span2_type    tmaj_ff, tmaj_in;
   bls_pkg::span2_type    tmin_ff, tmin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bls_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   logic                       out_free, is_start, emit, last;
   logic [bls_pkg::ERR_W:0]    err_sub, err_fix;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_start  = (cmd_chan.cmd.kind == bls_pkg::REQ_START);
   assign cmd_ready = is_start || !line_active_ff || out_free;
   assign emit      = cmd_chan.valid && cmd_ready && !is_start && line_active_ff;
   assign last      = ({1'b0, major_pos_ff} + 1'b1) == {1'b0, major_stop_ff};

   // error update: subtract twice the minor span, add back twice the major span on underflow
   assign err_sub = {err_ff[bls_pkg::ERR_W-1], err_ff} - {2'b00, tmin_ff};
   assign err_fix = err_sub[bls_pkg::ERR_W] ? err_sub + {2'b00, tmaj_ff} : err_sub;

   always_comb begin
      line_active_in    = line_active_ff;
      is_steep_in       = is_steep_ff;
      minor_dir_down_in = minor_dir_down_ff;
      major_pos_in      = major_pos_ff;
      major_stop_in     = major_stop_ff;
      minor_pos_in      = minor_pos_ff;
      err_in            = err_ff;
      tmaj_in           = tmaj_ff;
      tmin_in           = tmin_ff;
      rsp_valid_in      = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in       = rsp_data_ff;

      if (cmd_chan.valid && is_start) begin
         // load new line, drop any unfinished one
         line_active_in    = cmd_chan.cmd.active;
         is_steep_in       = cmd_chan.cmd.is_steep;
         minor_dir_down_in = cmd_chan.cmd.minor_dir_down;
         major_pos_in      = cmd_chan.cmd.major_pos;
         major_stop_in     = cmd_chan.cmd.major_stop;
         minor_pos_in      = cmd_chan.cmd.minor_pos;
         err_in            = cmd_chan.cmd.doubled_error;
         tmaj_in           = cmd_chan.cmd.twice_major_span;
         tmin_in           = cmd_chan.cmd.twice_minor_span;
      end else if (emit) begin
         // emit pixel and advance one major step
         rsp_valid_in         = 1'b1;
         rsp_data_in.pixel_x  = is_steep_ff ? minor_pos_ff : major_pos_ff;
         rsp_data_in.pixel_y  = is_steep_ff ? major_pos_ff : minor_pos_ff;
         rsp_data_in.last_pixel = last;
         err_in = err_fix[bls_pkg::ERR_W-1:0];
         if (err_sub[bls_pkg::ERR_W]) begin
            minor_pos_in = minor_dir_down_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
         end
         major_pos_in = major_pos_ff + 1'b1;
         if (last) begin
            line_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // hold line and pixel payload
   always_ff @(posedge clock) begin
      is_steep_ff       <= is_steep_in;
      minor_dir_down_ff <= minor_dir_down_in;
      major_pos_ff      <= major_pos_in;
      major_stop_ff     <= major_stop_in;
      minor_pos_ff      <= minor_pos_in;
      err_ff            <= err_in;
      tmaj_ff           <= tmaj_in;
      tmin_ff           <= tmin_in;
      rsp_data_ff       <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
